### rtl/plo_pkg.sv
// Shared types, sizes and helper functions for the priority ordered list.
// Used by plo_cell and priority_ordered_list; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package plo_pkg;

   localparam int CAPACITY       = 32;
   localparam int ID_WIDTH       = 16;
   localparam int PRIORITY_WIDTH = 8;

   localparam int KIND_W        = 2;
   localparam int POS_W         = 5;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 6;

   // count runs from 0 to CAPACITY inclusive
   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_NOP    = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_BAD_POS   = 2'd3
   } status_type;

   // one list entry as held in a cell
   typedef struct packed {
      logic [ID_WIDTH-1:0]       id;
      logic [PRIORITY_WIDTH-1:0] pri;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic      ins_en;
      logic      rem_en;
      entry_type entry;
   } cell_ctrl_type;

   // captured request
   typedef struct packed {
      kind_type                  kind;
      logic [ID_WIDTH-1:0]       id;
      logic [PRIORITY_WIDTH-1:0] pri;
      logic [POS_W-1:0]          position;
   } req_type;

   // bit k is set when any bit at or below k is set
   function automatic logic [CAPACITY-1:0] prefix_or(input logic [CAPACITY-1:0] vec);
      logic [CAPACITY-1:0] acc;
      acc = vec;
      for (int s = 1; s < CAPACITY; s = s * 2) begin
         acc = acc | (acc << s);
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

### rtl/priority_ordered_list.sv
// Top level of the priority ordered list: request capture, the chain of
// plo_cell slots, count and result registers. Depends on plo_pkg, plo_cell.
//
// Usage:
//   Present kind, entry_id, priority_req and position on the req_ ports and
//   raise start; the transfer happens at a rising edge with start high and
//   busy low. Kind insert places the entry behind every held entry of equal
//   or higher priority, remove deletes the first entry with a matching id,
//   read returns the entry at a position (0 is the head); kind 3 does nothing.
//   Every transfer produces exactly one result: rsp_strobe is high for one
//   cycle with status, out_id, out_priority and the entry count after it.
// Timing:
//   The request is registered at the accepting edge; during the next cycle
//   all slots compare in parallel and update together at the following edge,
//   where the result is registered and rsp_strobe rises. busy is high for
//   that one update cycle, and no new request is taken while busy is high.
// Reset:
//   Synchronous, active high; empties the list (count zero) and drops any
//   request in flight. Slot contents are not cleared; only slots below the
//   count are ever looked at. The receiver cannot stall: rsp_strobe is a
//   one-cycle strobe and every result must be taken when it appears.
`timescale 1ns / 1ps
`default_nettype none

module priority_ordered_list (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire  [plo_pkg::KIND_W-1:0]          req_kind,
   input  wire  [plo_pkg::ID_WIDTH-1:0]        req_entry_id,
   input  wire  [plo_pkg::PRIORITY_WIDTH-1:0]  req_priority_req,
   input  wire  [plo_pkg::POS_W-1:0]           req_position,
   output logic                                rsp_strobe,
   output logic [plo_pkg::STATUS_W-1:0]        rsp_status,
   output logic [plo_pkg::ID_WIDTH-1:0]        rsp_out_id,
   output logic [plo_pkg::PRIORITY_WIDTH-1:0]  rsp_out_priority,
   output logic [plo_pkg::ENTRY_COUNT_W-1:0]   rsp_entry_count
);
   import plo_pkg::*;

   // control state
   logic               busy_ff,   busy_in;
   logic               strobe_ff, strobe_in;
   logic [COUNT_W-1:0] count_ff,  count_in;

   // payload
   req_type                    req_ff,    req_in;
   status_type                 status_ff, status_in;
   logic [ID_WIDTH-1:0]        id_ff,     id_in;
   logic [PRIORITY_WIDTH-1:0]  pri_ff,    pri_in;
   logic [ENTRY_COUNT_W-1:0]   ecount_ff, ecount_in;

   logic                accept;
   cell_ctrl_type       ctrl;
   logic [CAPACITY-1:0] occupied;
   logic [CAPACITY-1:0] stay;
   logic [CAPACITY-1:0] match;
   logic [CAPACITY-1:0] prefix;
   logic [CAPACITY-1:0] left_stay;
   entry_type           cell_data  [CAPACITY];
   entry_type           left_data  [CAPACITY];
   entry_type           right_data [CAPACITY];
   logic                full;
   logic                found;
   logic                pos_ok;
   entry_type           rd_entry;

   assign accept = start && !busy_ff;

   // ---------------------------------------------------------------
   // Request capture: hold the request for the update cycle
   // ---------------------------------------------------------------
   always_comb begin
      req_in = req_ff;
      if (accept) begin
         req_in.kind     = kind_type'(req_kind);
         req_in.id       = req_entry_id;
         req_in.pri      = req_priority_req;
         req_in.position = req_position;
      end
   end

   assign busy_in = accept;

   // ---------------------------------------------------------------
   // Chain of slots
   // ---------------------------------------------------------------
   assign full  = (count_ff == COUNT_W'(CAPACITY));
   assign found = |match;

   // broadcast command; update only in the busy cycle
   always_comb begin
      ctrl.entry.id  = req_ff.id;
      ctrl.entry.pri = req_ff.pri;
      ctrl.ins_en    = busy_ff && (req_ff.kind == KIND_INSERT) && !full;
      ctrl.rem_en    = busy_ff && (req_ff.kind == KIND_REMOVE) && found;
   end

   // slot k holds a live entry when k is below the count
   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         occupied[k] = (CMP_W'(k) < CMP_W'(count_ff));
      end
   end

   // first match and every slot after it shift left on a remove
   assign prefix = prefix_or(match);

   // neighbor wiring: the head sees the new entry on its left,
   // the tail sees itself on its right
   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         if (k == 0) begin
            left_stay[k] = 1'b1;
            left_data[k] = ctrl.entry;
         end else begin
            left_stay[k] = stay[k-1];
            left_data[k] = cell_data[k-1];
         end
         if (k == CAPACITY - 1) begin
            right_data[k] = cell_data[k];
         end else begin
            right_data[k] = cell_data[k+1];
         end
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      plo_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .occupied     (occupied[g]),
         .left_stay    (left_stay[g]),
         .left_data    (left_data[g]),
         .right_data   (right_data[g]),
         .prefix_match (prefix[g]),
         .data         (cell_data[g]),
         .stay         (stay[g]),
         .match        (match[g])
      );
   end

   // ---------------------------------------------------------------
   // Read port: select the slot at the requested position
   // ---------------------------------------------------------------
   assign pos_ok = (CMP_W'(req_ff.position) < CMP_W'(count_ff));

   always_comb begin
      rd_entry = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         if (CMP_W'(req_ff.position) == CMP_W'(k)) begin
            rd_entry = cell_data[k];
         end
      end
   end

   // ---------------------------------------------------------------
   // Count and result
   // ---------------------------------------------------------------
   always_comb begin
      count_in = count_ff;
      if (ctrl.ins_en) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (ctrl.rem_en) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_comb begin
      status_in = STATUS_OK;
      id_in     = '0;
      pri_in    = '0;
      case (req_ff.kind)
         KIND_INSERT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end
         end
         KIND_REMOVE: begin
            if (!found) begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         KIND_READ: begin
            if (pos_ok) begin
               id_in  = rd_entry.id;
               pri_in = rd_entry.pri;
            end else begin
               status_in = STATUS_BAD_POS;
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   assign ecount_in = ENTRY_COUNT_W'(count_in);
   assign strobe_in = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (busy_ff) begin
         status_ff <= status_in;
         id_ff     <= id_in;
         pri_ff    <= pri_in;
         ecount_ff <= ecount_in;
      end
   end

   assign busy             = busy_ff;
   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_id       = id_ff;
   assign rsp_out_priority = pri_ff;
   assign rsp_entry_count  = ecount_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_busy_then_strobe: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> strobe_ff)
      else $error("update cycle not followed by a result strobe");

   a_strobe_not_busy: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> !busy_ff)
      else $error("result strobe overlaps an update cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && (status_ff == STATUS_FULL)) |->
         (count_ff == COUNT_W'(CAPACITY)))
      else $error("full status with room in the list");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(busy_ff) |-> (count_ff == $past(count_ff)))
      else $error("count changed outside an update cycle");

endmodule

`default_nettype wire

### rtl/plo_cell.sv
// One slot of the sorted chain: holds an entry, compares it against the
// broadcast command and shifts with its neighbors. Depends on plo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plo_cell (
   input  wire                         clock,
   input  wire plo_pkg::cell_ctrl_type ctrl,
   input  wire                         occupied,
   input  wire                         left_stay,
   input  wire plo_pkg::entry_type     left_data,
   input  wire plo_pkg::entry_type     right_data,
   input  wire                         prefix_match,
   output plo_pkg::entry_type          data,
   output logic                        stay,
   output logic                        match
);
   import plo_pkg::*;

   entry_type data_ff;
   entry_type data_in;

   // entry stays ahead of a new insert when its priority is not lower
   assign stay  = occupied && (data_ff.pri >= ctrl.entry.pri);
   assign match = occupied && (data_ff.id == ctrl.entry.id);
   assign data  = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins_en && !stay) begin
         // first slot past the stayers takes the new entry, the rest shift right
         data_in = left_stay ? ctrl.entry : left_data;
      end else if (ctrl.rem_en && prefix_match) begin
         // close the gap at and after the removed entry
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

### tb/priority_list_checker.sv
// Watches both channels of the priority ordered list, keeps its own sorted
// list and compares each result against the oldest expected one. Needs plo_pkg.
`timescale 1ns / 1ps

module priority_list_checker (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   input  wire                                 busy,
   input  wire  [plo_pkg::KIND_W-1:0]          req_kind,
   input  wire  [plo_pkg::ID_WIDTH-1:0]        req_entry_id,
   input  wire  [plo_pkg::PRIORITY_WIDTH-1:0]  req_priority_req,
   input  wire  [plo_pkg::POS_W-1:0]           req_position,
   input  wire                                 rsp_strobe,
   input  wire  [plo_pkg::STATUS_W-1:0]        rsp_status,
   input  wire  [plo_pkg::ID_WIDTH-1:0]        rsp_out_id,
   input  wire  [plo_pkg::PRIORITY_WIDTH-1:0]  rsp_out_priority,
   input  wire  [plo_pkg::ENTRY_COUNT_W-1:0]   rsp_entry_count,
   output int                                  error_count,
   output int                                  pending_count,
   output int                                  checked_count,
   output int                                  full_drops
);
   import plo_pkg::*;

   typedef struct packed {
      status_type                 status;
      logic [ID_WIDTH-1:0]        id;
      logic [PRIORITY_WIDTH-1:0]  pri;
      logic [ENTRY_COUNT_W-1:0]   count;
   } list_outcome_type;

   logic [ID_WIDTH-1:0]       held_ids  [CAPACITY];
   logic [PRIORITY_WIDTH-1:0] held_pris [CAPACITY];
   int                        held_count = 0;
   list_outcome_type          pending_outcomes [$];
   list_outcome_type          oldest;
   int                        errors  = 0;
   int                        checked = 0;
   int                        drops   = 0;

   assign error_count   = errors;
   assign checked_count = checked;
   assign full_drops    = drops;

   // apply one request to the shadow list and return what the block must answer
   function automatic list_outcome_type apply_request(input kind_type kind,
                                                      input logic [ID_WIDTH-1:0] id,
                                                      input logic [PRIORITY_WIDTH-1:0] pri,
                                                      input logic [POS_W-1:0] pos);
      list_outcome_type res;
      int               slot;
      res = '{status: STATUS_OK, id: '0, pri: '0, count: '0};
      slot = 0;
      case (kind)
         KIND_INSERT: begin
            if (held_count >= CAPACITY) begin
               res.status = STATUS_FULL;
               drops++;
            end else begin
               while (slot < held_count && held_pris[slot] >= pri) slot++;
               for (int k = held_count; k > slot; k--) begin
                  held_ids[k]  = held_ids[k-1];
                  held_pris[k] = held_pris[k-1];
               end
               held_ids[slot]  = id;
               held_pris[slot] = pri;
               held_count++;
            end
         end
         KIND_REMOVE: begin
            while (slot < held_count && held_ids[slot] != id) slot++;
            if (slot >= held_count) begin
               res.status = STATUS_NOT_FOUND;
            end else begin
               for (int k = slot; k + 1 < held_count; k++) begin
                  held_ids[k]  = held_ids[k+1];
                  held_pris[k] = held_pris[k+1];
               end
               held_count--;
            end
         end
         KIND_READ: begin
            if (int'(pos) < held_count) begin
               res.id  = held_ids[pos];
               res.pri = held_pris[pos];
            end else begin
               res.status = STATUS_BAD_POS;
            end
         end
         default: ;
      endcase
      res.count = held_count[ENTRY_COUNT_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         pending_outcomes.delete();
         pending_count <= 0;
      end else begin
         if (rsp_strobe) begin
            if (pending_outcomes.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, status %0d id %h priority %h count %0d",
                        $time, rsp_status, rsp_out_id, rsp_out_priority, rsp_entry_count);
            end else begin
               oldest = pending_outcomes.pop_front();
               checked++;
               if (rsp_status !== oldest.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, oldest.status, rsp_status);
               end
               if (rsp_out_id !== oldest.id) begin
                  errors++;
                  $display("%0t: out_id expected %h actual %h", $time, oldest.id, rsp_out_id);
               end
               if (rsp_out_priority !== oldest.pri) begin
                  errors++;
                  $display("%0t: out_priority expected %h actual %h",
                           $time, oldest.pri, rsp_out_priority);
               end
               if (rsp_entry_count !== oldest.count) begin
                  errors++;
                  $display("%0t: entry_count expected %0d actual %0d",
                           $time, oldest.count, rsp_entry_count);
               end
            end
         end
         if (start && !busy) begin
            pending_outcomes.push_back(apply_request(kind_type'(req_kind), req_entry_id,
                                                     req_priority_req, req_position));
         end
         pending_count <= pending_outcomes.size();
      end
   end

endmodule

### tb/priority_ordered_list_test.sv
// Top of the priority ordered list test: clock, reset, request stimulus and
// the verdict. Depends on plo_pkg, priority_ordered_list, priority_list_checker.
`timescale 1ns / 1ps

module priority_ordered_list_test;
   import plo_pkg::*;

   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 275;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       start            = 1'b0;
   logic [KIND_W-1:0]          req_kind         = KIND_NOP;
   logic [ID_WIDTH-1:0]        req_entry_id     = '0;
   logic [PRIORITY_WIDTH-1:0]  req_priority_req = '0;
   logic [POS_W-1:0]           req_position     = '0;
   wire                        busy;
   wire                        rsp_strobe;
   wire  [STATUS_W-1:0]        rsp_status;
   wire  [ID_WIDTH-1:0]        rsp_out_id;
   wire  [PRIORITY_WIDTH-1:0]  rsp_out_priority;
   wire  [ENTRY_COUNT_W-1:0]   rsp_entry_count;

   int error_count;
   int pending_count;
   int checked_count;
   int full_drops;

   // pacing: chance in a hundred that the sender's idle gap before a request grows
   int idle_pct;
   int sent_by_kind [4];

   priority_ordered_list uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_entry_id     (req_entry_id),
      .req_priority_req (req_priority_req),
      .req_position     (req_position),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_priority (rsp_out_priority),
      .rsp_entry_count  (rsp_entry_count)
   );

   priority_list_checker order_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_entry_id     (req_entry_id),
      .req_priority_req (req_priority_req),
      .req_position     (req_position),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_priority (rsp_out_priority),
      .rsp_entry_count  (rsp_entry_count),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count),
      .full_drops       (full_drops)
   );

   always #1 clock = ~clock;

   // Present one request and hold it until the transfer edge. Start stays
   // high on return so a back-to-back request needs no extra edge; the next
   // call either drops it for an idle gap or overwrites the payload.
   task automatic send_item(input kind_type kind, input logic [ID_WIDTH-1:0] id,
                            input logic [PRIORITY_WIDTH-1:0] pri,
                            input logic [POS_W-1:0] pos);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_kind         <= kind;
      req_entry_id     <= id;
      req_priority_req <= pri;
      req_position     <= pos;
      sent_by_kind[kind]++;
      // wait for an edge where busy was low: that edge takes the request
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start and hold off until every outstanding result has arrived.
   // The first edge lets the checker count the request just taken.
   task automatic drain_results;
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Mostly a small id space so removes hit held entries and duplicates
   // occur; now and then a full-width id to toggle every bit.
   function automatic logic [ID_WIDTH-1:0] pick_id;
      if ($urandom_range(99) < 80) return ID_WIDTH'($urandom_range(15));
      return ID_WIDTH'($urandom);
   endfunction

   // Narrow priorities give plenty of ties; full range covers the extremes.
   function automatic logic [PRIORITY_WIDTH-1:0] pick_priority;
      if ($urandom_range(99) < 60) return PRIORITY_WIDTH'($urandom_range(7));
      return PRIORITY_WIDTH'($urandom);
   endfunction

   initial begin
      int       pace      [PHASES];
      int       fill_bias [PHASES];
      int       roll;
      int       wait_cycles;
      kind_type kind;

      pace      = '{0, 83, 18, 0, 83, 18};
      fill_bias = '{70, 30, 50, 85, 20, 50};
      idle_pct  = 0;
      sent_by_kind = '{0, 0, 0, 0};

      // hold reset, then release at an edge
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty-list corner cases first
      send_item(KIND_READ,   16'h0000, 8'h00, 5'd0);    // read on empty list
      send_item(KIND_REMOVE, 16'h0000, 8'h00, 5'd0);    // remove on empty list
      send_item(KIND_NOP,    16'hFFFF, 8'hFF, 5'd31);   // unused kind, all fields high
      // extremes of id and priority, with duplicate ids and priority ties
      send_item(KIND_INSERT, 16'h0000, 8'h00, 5'd0);
      send_item(KIND_INSERT, 16'hFFFF, 8'hFF, 5'd31);
      send_item(KIND_INSERT, 16'h1234, 8'h80, 5'd0);
      send_item(KIND_INSERT, 16'hFFFF, 8'hFF, 5'd0);    // same id, tie behind the first
      send_item(KIND_INSERT, 16'h0000, 8'h00, 5'd0);    // tie at the tail
      send_item(KIND_INSERT, 16'h5555, 8'hAA, 5'd0);
      // walk the list, then read at and far past the count
      for (int p = 0; p < 7; p++) send_item(KIND_READ, 16'h0000, 8'h00, POS_W'(p));
      send_item(KIND_READ,   16'h0000, 8'h00, 5'd31);
      // remove the duplicate nearest the head, then an absent id
      send_item(KIND_REMOVE, 16'hFFFF, 8'h00, 5'd0);
      send_item(KIND_READ,   16'h0000, 8'h00, 5'd0);
      send_item(KIND_REMOVE, 16'h4321, 8'h00, 5'd0);
      send_item(KIND_REMOVE, 16'h0000, 8'h00, 5'd0);
      send_item(KIND_READ,   16'h0000, 8'h00, 5'd4);
      drain_results();

      // random phases: alternate pacing and bias toward filling or draining
      for (int ph = 0; ph < PHASES; ph++) begin
         idle_pct = pace[ph];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
               kind = KIND_NOP;
            end else if ($urandom_range(99) < fill_bias[ph]) begin
               kind = KIND_INSERT;
            end else if ($urandom_range(99) < 55) begin
               kind = KIND_READ;
            end else begin
               kind = KIND_REMOVE;
            end
            send_item(kind, pick_id(), pick_priority(), POS_W'($urandom_range(31)));
         end
         // pause the sender until the block has answered everything
         drain_results();
      end

      // let any stray result show up, bounded
      for (wait_cycles = 0; pending_count != 0 && wait_cycles < 200; wait_cycles++)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (pending_count != 0)
         $display("%0t: %0d results never arrived", $time, pending_count);
      $display("Sent %0d inserts, %0d removes, %0d reads and %0d no-ops over %0d phases;",
               sent_by_kind[KIND_INSERT], sent_by_kind[KIND_REMOVE],
               sent_by_kind[KIND_READ], sent_by_kind[KIND_NOP], PHASES);
      $display("%0d results compared, %0d inserts dropped on a full list.",
               checked_count, full_drops);
      if (error_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #400000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
